### hdl/fcsp_pkg.sv
// Shared types, constants and reset values for the four-channel servo PWM block.
`default_nettype none

package fcsp_pkg;

  localparam int unsigned CHANNELS_DEF  = 4;
  localparam int unsigned FINE_SPAN_DEF = 250;

  localparam logic [7:0]  COARSE_LIMIT_RST   = 8'd120;
  localparam logic [15:0] COMPARE_MAX_RST    = 16'd2000;
  localparam logic [15:0] COMPARE_OFFSET_RST = 16'd1000;
  localparam logic [15:0] FULL_SCALE_RST     = 16'd20000;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CTRL   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_COARSE_LIMIT   = 2'd0,
    REG_COMPARE_MAX    = 2'd1,
    REG_COMPARE_OFFSET = 2'd2,
    REG_FULL_SCALE     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } ctl_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] ctrl_bits;
    logic [7:0] fine_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  pwm_out;
    logic [15:0] period_count;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [15:0] time_val;
    logic [15:0] span;
    logic [15:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } md_rsp_t;

endpackage

`default_nettype wire

### hdl/fcsp_muldiv.sv
// Bit-serial multiply then restoring divide: quotient = time * span / divisor.
`default_nettype none

module fcsp_muldiv import fcsp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire md_req_t req_i,
  output md_rsp_t      rsp_o
);

  md_state_e   state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] rem_q, rem_d;

  logic [16:0] mul_sum;
  logic [16:0] div_sh;
  logic [17:0] div_diff;
  logic        div_ge;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_MUL;
      MD_MUL:  if (cnt_q == 5'd0) state_d = MD_DIV;
      MD_DIV:  if (cnt_q == 5'd0) state_d = MD_DONE;
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  // shift-add: one multiplier bit per cycle; restoring divide: one quotient bit per cycle
  always_comb begin
    mul_sum  = {1'b0, acc_q[31:16]} + (acc_q[0] ? {1'b0, req_i.span} : 17'd0);
    div_sh   = {rem_q, acc_q[31]};
    div_diff = {1'b0, div_sh} - {2'b00, req_i.divisor};
    div_ge   = ~div_diff[17];
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_d = {16'd0, req_i.time_val};
          cnt_d = 5'd15;
        end
      end
      MD_MUL: begin
        acc_d = {mul_sum, acc_q[15:1]};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          cnt_d = 5'd31;
          rem_d = 16'd0;
        end
      end
      MD_DIV: begin
        acc_d = {acc_q[30:0], div_ge};
        rem_d = div_ge ? div_diff[15:0] : div_sh[15:0];
        cnt_d = cnt_q - 5'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_o.done     = (state_q == MD_DONE);
    rsp_o.quotient = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

endmodule

`default_nettype wire

### hdl/fcsp_outbuf.sv
// Result register with a one-entry skid stage on the output channel.
`default_nettype none

module fcsp_outbuf import fcsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t push_data_i,
  output logic           skid_full_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      drain;

  always_comb begin
    drain        = out_valid_q && out_ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (push_i) begin
      if (!out_valid_q || drain) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (drain) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hdl/four_channel_servo_pwm.sv
// Top level of the four-channel servo PWM generator.
// Requests arrive on the in channel (valid/ready) as sample, coarse-tick or control
// items; every request yields exactly one result (output levels, period count) on
// the out channel. Registers are written on the cfg channel, which is always ready,
// and must only be written while the block is idle.
// Sample and coarse-tick results are formed in the accepting cycle and loaded at the
// accepting edge into the output register, or into the skid stage if the output stalls.
// A control request steps the pulse times, then recomputes every compare value on
// one shared bit-serial multiply/divide unit, one channel after another.
// No further request is taken until it has finished.
// When the receiver stalls, one more result is held in a skid stage; after that
// in_ready_o drops until the output drains.
// Reset restores the register defaults and clears pulse times, compare values,
// the coarse counter, the output levels and the period count.
`default_nettype none

module four_channel_servo_pwm import fcsp_pkg::*; #(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned FINE_SPAN = FINE_SPAN_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LvN  = (CHANNELS < 4) ? CHANNELS : 4;
  localparam logic [8:0]  FineSpan = 9'(FINE_SPAN);
  localparam logic [ChW-1:0] LastCh = ChW'(CHANNELS - 1);

  logic [7:0]  coarse_limit_q;
  logic [15:0] compare_max_q;
  logic [15:0] compare_offset_q;
  logic [15:0] full_scale_q;

  logic [15:0] pulse_q   [CHANNELS];
  logic [15:0] compare_q [CHANNELS];
  logic [7:0]  coarse_q, coarse_d;
  logic [3:0]  levels_q, levels_d;
  logic [15:0] last_q, last_d;

  ctl_state_e     state_q, state_d;
  logic [ChW-1:0] ch_q, ch_d;

  logic      in_acc;
  op_e       op;
  logic      skid_full;
  logic      push;
  out_item_t push_data;
  logic      cmp_we;
  logic      is_last;

  logic [15:0] ctrl_ext;
  logic [8:0]  coarse_inc;
  logic [16:0] coarse_prod;
  logic [15:0] sample_count;
  logic [3:0]  sample_lv;

  md_req_t     md_req;
  md_rsp_t     md_rsp;
  logic [32:0] scaled_sum;
  logic [15:0] cmp_new;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_limit_q   <= COARSE_LIMIT_RST;
      compare_max_q    <= COMPARE_MAX_RST;
      compare_offset_q <= COMPARE_OFFSET_RST;
      full_scale_q     <= FULL_SCALE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COARSE_LIMIT:   coarse_limit_q   <= cfg_data_i[7:0];
        REG_COMPARE_MAX:    compare_max_q    <= cfg_data_i;
        REG_COMPARE_OFFSET: compare_offset_q <= cfg_data_i;
        REG_FULL_SCALE:     full_scale_q     <= cfg_data_i;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && !skid_full;
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = op_e'(in_data_i.opcode);

  // sample and tick requests settle in the accepting cycle
  always_comb begin
    coarse_inc   = {1'b0, coarse_q} + 9'd1;
    coarse_prod  = coarse_q * FineSpan;
    sample_count = coarse_prod[15:0] + {8'd0, in_data_i.fine_count};
    sample_lv    = 4'd0;
    for (int k = 0; k < LvN; k++) begin
      sample_lv[k] = (sample_count < compare_q[k]);
    end
    coarse_d = coarse_q;
    levels_d = levels_q;
    last_d   = last_q;
    if (in_acc) begin
      case (op)
        OP_SAMPLE: begin
          levels_d = sample_lv;
          last_d   = sample_count;
        end
        OP_TICK: begin
          if (coarse_inc > {1'b0, coarse_limit_q}) begin
            coarse_d = 8'd0;
            last_d   = 16'd0;
          end else begin
            coarse_d = coarse_inc[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_q <= 8'd0;
      levels_q <= 4'd0;
      last_q   <= 16'd0;
    end else begin
      coarse_q <= coarse_d;
      levels_q <= levels_d;
      last_q   <= last_d;
    end
  end

  // up step first, then down step
  assign ctrl_ext = {8'd0, in_data_i.ctrl_bits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        pulse_q[k]   <= 16'd0;
        compare_q[k] <= 16'd0;
      end
    end else begin
      if (in_acc && op == OP_CTRL) begin
        for (int k = 0; k < CHANNELS; k++) begin
          logic [15:0] t;
          t = pulse_q[k];
          if (ctrl_ext[2*k] && t < full_scale_q) t = t + 16'd1;
          if (ctrl_ext[2*k+1] && t != 16'd0) t = t - 16'd1;
          pulse_q[k] <= t;
        end
      end
      if (cmp_we) compare_q[ch_q] <= cmp_new;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && op == OP_CTRL) state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT:  if (md_rsp.done) state_d = is_last ? ST_IDLE : ST_ISSUE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    is_last        = (ch_q == LastCh);
    md_req.start   = (state_q == ST_ISSUE);
    md_req.time_val = pulse_q[ch_q];
    md_req.span    = compare_max_q - compare_offset_q;
    md_req.divisor = full_scale_q;
    cmp_we         = (state_q == ST_WAIT) && md_rsp.done;
    ch_d           = ch_q;
    if (state_q == ST_IDLE) begin
      ch_d = '0;
    end else if (cmp_we) begin
      ch_d = is_last ? '0 : ch_q + ChW'(1);
    end
    push = (in_acc && op != OP_CTRL) || (cmp_we && is_last);
  end

  // a negative span or zero full scale always ends at the offset
  always_comb begin
    scaled_sum = {17'd0, compare_offset_q} + {1'b0, md_rsp.quotient};
    if (compare_max_q < compare_offset_q || full_scale_q == 16'd0) begin
      cmp_new = compare_offset_q;
    end else if (scaled_sum > {17'd0, compare_max_q}) begin
      cmp_new = compare_max_q;
    end else begin
      cmp_new = scaled_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  always_comb begin
    push_data.pwm_out      = levels_d;
    push_data.period_count = last_d;
  end

  fcsp_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  fcsp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .skid_full_o (skid_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
